@@ rtl/mtbr_pkg.sv @@
// Package for the bounded MT19937 generator: constants, state codes and tempering.
// Used by mt19937_bounded_random.
`default_nettype none
package mtbr_pkg;
    localparam int TBL_N = 624;
    localparam int TBL_M = 397;
    localparam int IDX_W = 10;
    localparam logic [31:0] TWIST_XOR  = 32'h9908B0DF;
    localparam logic [31:0] TEMPER_B   = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C   = 32'hEFC60000;
    localparam logic [31:0] HI_BIT     = 32'h80000000;
    localparam logic [31:0] LO_BITS    = 32'h7FFFFFFF;
    localparam logic [31:0] SEED_MULT  = 32'd6069;
    localparam logic [31:0] SEED_RESET = 32'd4357;
    localparam logic [31:0] SIGNED_TOP = 32'h7FFFFFFF;
    localparam logic [IDX_W-1:0] UNSEEDED = 10'd625;
    localparam int MAX_COUNT_DEF = 64;

    localparam logic CFG_SEED  = 1'b0;
    localparam logic CFG_BOUND = 1'b1;
    localparam logic MODE_DRAW   = 1'b0;
    localparam logic MODE_RESEED = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIMIT_GO,
        ST_LIMIT_WAIT,
        ST_SEED,
        ST_TW_RD0,
        ST_TW_RD1,
        ST_TW_RD2,
        ST_TW_WR,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_TEST,
        ST_MOD_WAIT,
        ST_OUT
    } state_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction
endpackage
`default_nettype wire

@@ rtl/mtbr_divider.sv @@
// Restoring divider, one quotient bit per cycle; gives the 32-bit remainder.
// Uses no package items.
`default_nettype none
module mtbr_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [31:0]      remainder
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[31]};
        trial     = shifted - {1'b0, div_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[30:0], ~trial[32]};
            rem_next = trial[32] ? shifted[31:0] : trial[31:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg)) else $error("done without work");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= 6'd31) else $error("divider count overrun");
endmodule
`default_nettype wire

@@ rtl/mt19937_bounded_random.sv @@
// Top level of the bounded MT19937 generator: table memory, sequencer, output register.
// Depends on mtbr_pkg and mtbr_divider.
//
// Usage: a request carries the mode on s_tuser and the count on s_tdata[6:0].
// mode 1 refills the 624-word table from seed_word and gives no result;
// mode 0 gives count values (1..MAX_COUNT, larger saturates, 0 gives nothing)
// on m_tdata, with m_tlast on the final one. s_tready is high only in idle,
// so one request is worked at a time.
// Sequence: a draw request first computes the limit in the bit-serial
// remainder unit (skipped with bound 0); a reseed, or the first draw after
// reset, seeds the table word by word; a twist, reading three words per word
// through the table's one read port and then writing it, runs once every 624
// words. Each accepted word passes fetch and test, the bit-serial remainder
// unit (skipped with bound 0) and the output register; after a rejected word the next one is fetched.
// A result sits in the output register until m_tready; meanwhile the sequencer
// works on and waits in ST_OUT with the next result. Reset clears the control
// state and marks the table unseeded; the first draw seeds it. cfg writes
// (index 0 seed_word, 1 bound) are always taken and should be done while idle.
`default_nettype none
module mt19937_bounded_random #(
    parameter int MAX_COUNT = mtbr_pkg::MAX_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [6:0] count, [7] zero
    input  wire logic        s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] value
    output logic             m_tlast,   // last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int IW = mtbr_pkg::IDX_W;

    logic [31:0] mem [mtbr_pkg::TBL_N];
    logic [31:0] rd_data_reg;
    logic        we;
    logic [IW-1:0] waddr, raddr;
    logic [31:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    mtbr_pkg::state_t state_reg, state_next;
    logic [31:0] seed_reg, bound_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] k_reg, k_next;
    logic [6:0]  left_reg, left_next;
    logic [31:0] limit_reg, limit_next;
    logic [31:0] prev_reg, prev_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] w_reg, w_next;
    logic        ov_reg, ov_next;
    logic [31:0] ovd_reg, ovd_next;
    logic        ol_reg, ol_next;
    logic        drawing_reg, drawing_next;

    logic        dv_start;
    logic [31:0] dv_a, dv_b, dv_rem;
    logic        dv_busy, dv_done;

    mtbr_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
        .divisor(dv_b), .busy(dv_busy), .done(dv_done), .remainder(dv_rem)
    );

    logic [6:0]  cnt_in;
    logic [6:0]  cnt_sat;
    logic [IW-1:0] k1, km;
    logic [31:0] y, mix, temp;

    always_comb
    begin
        cnt_in  = s_tdata[6:0];
        cnt_sat = (cnt_in > 7'(MAX_COUNT)) ? 7'(MAX_COUNT) : cnt_in;
        k1 = (k_reg == IW'(mtbr_pkg::TBL_N - 1)) ? '0 : k_reg + IW'(1);
        km = (k_reg >= IW'(mtbr_pkg::TBL_N - mtbr_pkg::TBL_M))
            ? k_reg - IW'(mtbr_pkg::TBL_N - mtbr_pkg::TBL_M)
            : k_reg + IW'(mtbr_pkg::TBL_M);
        y    = (a_reg & mtbr_pkg::HI_BIT) | (b_reg & mtbr_pkg::LO_BITS);
        mix  = (y >> 1) ^ (y[0] ? mtbr_pkg::TWIST_XOR : 32'd0);
        temp = mtbr_pkg::temper(rd_data_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg; k_next = k_reg; left_next = left_reg;
        limit_next = limit_reg; prev_next = prev_reg;
        a_next = a_reg; b_next = b_reg; w_next = w_reg;
        ov_next = ov_reg; ovd_next = ovd_reg; ol_next = ol_reg;
        we = 1'b0; waddr = k_reg; wdata = '0; raddr = k_reg;
        dv_start = 1'b0; dv_a = mtbr_pkg::SIGNED_TOP; dv_b = bound_reg;
        s_tready = 1'b0;
        if (ov_reg && m_tready)
            ov_next = 1'b0;
        case (state_reg)
            mtbr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == mtbr_pkg::MODE_RESEED)
                    begin
                        k_next = '0;
                        prev_next = seed_reg;
                        state_next = mtbr_pkg::ST_SEED;
                    end
                    else if (cnt_sat != 7'd0)
                    begin
                        left_next = cnt_sat;
                        state_next = mtbr_pkg::ST_LIMIT_GO;
                    end
                end
            end
            mtbr_pkg::ST_LIMIT_GO:
            begin
                if (bound_reg == 32'd0)
                begin
                    limit_next = mtbr_pkg::SIGNED_TOP;
                    state_next = (idx_reg >= mtbr_pkg::UNSEEDED)
                        ? mtbr_pkg::ST_SEED : mtbr_pkg::ST_FETCH;
                end
                else
                begin
                    dv_start = 1'b1;
                    state_next = mtbr_pkg::ST_LIMIT_WAIT;
                end
                if (idx_reg >= mtbr_pkg::UNSEEDED)
                begin
                    k_next = '0;
                    prev_next = seed_reg;
                end
            end
            mtbr_pkg::ST_LIMIT_WAIT:
            begin
                if (dv_done)
                begin
                    limit_next = mtbr_pkg::SIGNED_TOP - dv_rem;
                    state_next = (idx_reg >= mtbr_pkg::UNSEEDED)
                        ? mtbr_pkg::ST_SEED : mtbr_pkg::ST_FETCH;
                end
            end
            mtbr_pkg::ST_SEED:
            begin
                we = 1'b1;
                wdata = (k_reg == '0) ? prev_reg : prev_reg * mtbr_pkg::SEED_MULT;
                prev_next = wdata;
                if (k_reg == IW'(mtbr_pkg::TBL_N - 1))
                begin
                    idx_next = IW'(mtbr_pkg::TBL_N);
                    k_next = '0;
                    state_next = drawing_reg ? mtbr_pkg::ST_FETCH : mtbr_pkg::ST_IDLE;
                end
                else
                    k_next = k_reg + IW'(1);
            end
            mtbr_pkg::ST_TW_RD0:
            begin
                raddr = k_reg;
                state_next = mtbr_pkg::ST_TW_RD1;
            end
            mtbr_pkg::ST_TW_RD1:
            begin
                raddr = k1;
                a_next = rd_data_reg;
                state_next = mtbr_pkg::ST_TW_RD2;
            end
            mtbr_pkg::ST_TW_RD2:
            begin
                raddr = km;
                b_next = rd_data_reg;
                state_next = mtbr_pkg::ST_TW_WR;
            end
            mtbr_pkg::ST_TW_WR:
            begin
                we = 1'b1;
                waddr = k_reg;
                wdata = rd_data_reg ^ mix;
                if (k_reg == IW'(mtbr_pkg::TBL_N - 1))
                begin
                    idx_next = '0;
                    k_next = '0;
                    state_next = mtbr_pkg::ST_FETCH;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                    state_next = mtbr_pkg::ST_TW_RD0;
                end
            end
            mtbr_pkg::ST_FETCH:
            begin
                if (idx_reg >= IW'(mtbr_pkg::TBL_N))
                begin
                    k_next = '0;
                    state_next = mtbr_pkg::ST_TW_RD0;
                end
                else
                begin
                    raddr = idx_reg;
                    idx_next = idx_reg + IW'(1);
                    state_next = mtbr_pkg::ST_FETCH_WAIT;
                end
            end
            mtbr_pkg::ST_FETCH_WAIT:
            begin
                w_next = temp;
                state_next = mtbr_pkg::ST_TEST;
            end
            mtbr_pkg::ST_TEST:
            begin
                if (w_reg[31] || w_reg <= limit_reg)
                begin
                    if (bound_reg == 32'd0)
                        state_next = mtbr_pkg::ST_OUT;
                    else
                    begin
                        dv_start = 1'b1;
                        dv_a = w_reg;
                        state_next = mtbr_pkg::ST_MOD_WAIT;
                    end
                end
                else
                    state_next = mtbr_pkg::ST_FETCH;
            end
            mtbr_pkg::ST_MOD_WAIT:
            begin
                if (dv_done)
                begin
                    w_next = dv_rem;
                    state_next = mtbr_pkg::ST_OUT;
                end
            end
            mtbr_pkg::ST_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    ovd_next = w_reg;
                    ol_next = (left_reg == 7'd1);
                    left_next = left_reg - 7'd1;
                    state_next = (left_reg == 7'd1) ? mtbr_pkg::ST_IDLE
                                                    : mtbr_pkg::ST_FETCH;
                end
            end
            default: state_next = mtbr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        drawing_next = drawing_reg;
        if (state_reg == mtbr_pkg::ST_IDLE && s_tvalid)
            drawing_next = (s_tuser == mtbr_pkg::MODE_DRAW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mtbr_pkg::ST_IDLE;
            idx_reg     <= mtbr_pkg::UNSEEDED;
            left_reg    <= '0;
            ov_reg      <= 1'b0;
            drawing_reg <= 1'b0;
            seed_reg    <= mtbr_pkg::SEED_RESET;
            bound_reg   <= 32'd1;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            left_reg    <= left_next;
            ov_reg      <= ov_next;
            drawing_reg <= drawing_next;
            k_reg       <= k_next;
            if (cfg_valid && cfg_index == mtbr_pkg::CFG_SEED)
                seed_reg <= cfg_data;
            if (cfg_valid && cfg_index == mtbr_pkg::CFG_BOUND)
                bound_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg <= limit_next;
        prev_reg  <= prev_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        w_reg     <= w_next;
        ovd_reg   <= ovd_next;
        ol_reg    <= ol_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = ovd_reg;
    assign m_tlast   = ol_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mtbr_pkg::ST_OUT && ov_reg && !m_tready)
        |=> state_reg == mtbr_pkg::ST_OUT) else $error("result overwritten");
    a_idx_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mtbr_pkg::ST_FETCH_WAIT |-> idx_reg <= IW'(mtbr_pkg::TBL_N))
        else $error("read index beyond table");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dv_start |-> !dv_busy) else $error("divider restarted while busy");
    a_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mtbr_pkg::ST_TEST |-> left_reg != 7'd0)
        else $error("draw with nothing left");
endmodule
`default_nettype wire
